// ----- hw/rtl/tcaf_pkg.sv -----
// Shared types and constants for the two-class age-ordered fifo unit.
// Used by tcaf_ctrl, tcaf_dpath and two_class_age_ordered_fifo_unit.
`timescale 1ns / 1ps

package tcaf_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STAMP_BITS  = 16;
    localparam int ID_W        = 32;

    // command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_TAKE_DOG = 2'd1;
    localparam logic [1:0] CMD_TAKE_CAT = 2'd2;
    localparam logic [1:0] CMD_TAKE_ANY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // command beat
    typedef struct packed {
        logic [1:0]      cmd;
        logic            is_dog;
        logic [ID_W-1:0] entry_id;
    } t_in;

    // result beat
    typedef struct packed {
        logic [ID_W-1:0] taken_id;
        logic            taken_from_dog;
        logic [1:0]      status;
        logic            dog_queue_empty;
        logic            cat_queue_empty;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

    // one stored queue entry
    typedef struct packed {
        logic [STAMP_BITS-1:0] stamp;
        logic [ID_W-1:0]       id;
    } t_entry;

endpackage

// ----- hw/rtl/tcaf_ctrl.sv -----
// Sequencer for the two-class age-ordered fifo unit: accepts a command,
// runs the execute step and raises the result strobe. Depends on tcaf_pkg.
`timescale 1ns / 1ps

module tcaf_ctrl
    import tcaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output logic o_valid,
    output t_ctl o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_valid, n_valid;
    logic   accept;

    // command beat taken when idle
    assign accept = i_start && !r_busy;

    // next state and registered outputs
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                    n_busy  = 1'b1;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign o_busy     = r_busy;
    assign o_valid    = r_valid;
    assign o_ctl.load = accept;
    assign o_ctl.exec = (r_state == S_EXEC);

endmodule

// ----- hw/rtl/tcaf_dpath.sv -----
// Datapath of the two-class age-ordered fifo unit: both queue memories,
// head/count pointers, the stamp counter and the result register. Uses tcaf_pkg.
`timescale 1ns / 1ps

module tcaf_dpath
    import tcaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_in  i_item,
    output t_out o_result
);

    localparam logic [PTR_W:0] DEPTH_W = (PTR_W+1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // queue storage
    t_entry dog_mem [QUEUE_DEPTH];
    t_entry cat_mem [QUEUE_DEPTH];

    t_in                   r_item;
    t_entry                r_dog_rd, r_cat_rd;
    logic [PTR_W-1:0]      r_dog_head, r_cat_head, n_dog_head, n_cat_head;
    logic [CNT_W-1:0]      r_dog_count, r_cat_count, n_dog_count, n_cat_count;
    logic [STAMP_BITS-1:0] r_next_stamp, n_next_stamp, stamp_diff;
    t_out                  r_result, n_result, res_beat;

    logic                  dog_ne, cat_ne, pick_dog, full, do_push, do_pop;
    logic                  push_dog, push_cat;
    logic [PTR_W-1:0]      tail, head_inc;
    logic [PTR_W:0]        tail_sum, inc_sum;

    // capture the beat and read both heads
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item   <= i_item;
            r_dog_rd <= dog_mem[r_dog_head];
            r_cat_rd <= cat_mem[r_cat_head];
        end
    end

    // execute: class choice, push/pop, status
    always_comb begin
        dog_ne     = (r_dog_count != '0);
        cat_ne     = (r_cat_count != '0);
        stamp_diff = r_dog_rd.stamp - r_cat_rd.stamp;
        full       = r_item.is_dog ? (r_dog_count == DEPTH_C)
                                   : (r_cat_count == DEPTH_C);
        pick_dog   = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        n_result   = '0;

        unique case (r_item.cmd)
            CMD_ADD: begin
                do_push = !full;
                n_result.status = full ? ST_FULL : ST_OK;
            end
            CMD_TAKE_DOG: pick_dog = 1'b1;
            CMD_TAKE_CAT: pick_dog = 1'b0;
            CMD_TAKE_ANY: begin
                // wrap-aware age compare, cat wins ties
                if (dog_ne && cat_ne) begin
                    pick_dog = stamp_diff[STAMP_BITS-1];
                end else begin
                    pick_dog = dog_ne;
                end
            end
            default: pick_dog = 1'b0;
        endcase

        if (r_item.cmd != CMD_ADD) begin
            if (pick_dog ? dog_ne : cat_ne) begin
                do_pop                  = 1'b1;
                n_result.status         = ST_OK;
                n_result.taken_id       = pick_dog ? r_dog_rd.id : r_cat_rd.id;
                n_result.taken_from_dog = pick_dog;
            end else begin
                n_result.status = ST_EMPTY;
            end
        end
    end

    // tail slot and head advance, modulo depth
    assign tail_sum = {1'b0, (r_item.is_dog ? r_dog_head : r_cat_head)}
                    + (PTR_W+1)'(r_item.is_dog ? r_dog_count : r_cat_count);
    assign tail     = (tail_sum >= DEPTH_W) ? PTR_W'(tail_sum - DEPTH_W)
                                            : tail_sum[PTR_W-1:0];
    assign inc_sum  = {1'b0, (pick_dog ? r_dog_head : r_cat_head)} + 1'b1;
    assign head_inc = (inc_sum >= DEPTH_W) ? '0 : inc_sum[PTR_W-1:0];

    assign push_dog = i_ctl.exec && do_push && r_item.is_dog;
    assign push_cat = i_ctl.exec && do_push && !r_item.is_dog;

    // pointer and counter updates
    always_comb begin
        n_dog_head   = r_dog_head;
        n_cat_head   = r_cat_head;
        n_dog_count  = r_dog_count;
        n_cat_count  = r_cat_count;
        n_next_stamp = r_next_stamp;
        if (do_push) begin
            n_next_stamp = r_next_stamp + 1'b1;
            if (r_item.is_dog) begin
                n_dog_count = r_dog_count + 1'b1;
            end else begin
                n_cat_count = r_cat_count + 1'b1;
            end
        end
        if (do_pop) begin
            if (pick_dog) begin
                n_dog_head  = head_inc;
                n_dog_count = r_dog_count - 1'b1;
            end else begin
                n_cat_head  = head_inc;
                n_cat_count = r_cat_count - 1'b1;
            end
        end
    end

    // queue writes
    always_ff @(posedge i_clk) begin
        if (push_dog) begin
            dog_mem[tail] <= '{stamp: r_next_stamp, id: r_item.entry_id};
        end
        if (push_cat) begin
            cat_mem[tail] <= '{stamp: r_next_stamp, id: r_item.entry_id};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dog_head   <= '0;
            r_cat_head   <= '0;
            r_dog_count  <= '0;
            r_cat_count  <= '0;
            r_next_stamp <= '0;
        end else if (i_ctl.exec) begin
            r_dog_head   <= n_dog_head;
            r_cat_head   <= n_cat_head;
            r_dog_count  <= n_dog_count;
            r_cat_count  <= n_cat_count;
            r_next_stamp <= n_next_stamp;
        end
    end

    // result beat with the empty flags after this step
    always_comb begin
        res_beat                 = n_result;
        res_beat.dog_queue_empty = (n_dog_count == '0);
        res_beat.cat_queue_empty = (n_cat_count == '0);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_result <= res_beat;
        end
    end

    assign o_result = r_result;

endmodule

// ----- hw/rtl/two_class_age_ordered_fifo_unit.sv -----
// Top level of the two-class age-ordered fifo unit.
// Built from tcaf_ctrl and tcaf_dpath; types from tcaf_pkg.
//
// Usage:
//   A command beat (i_item: cmd, is_dog, entry_id) is taken at a rising
//   edge where start is high and busy is low. Commands are add, take the
//   oldest dog, take the oldest cat, or take the oldest of either class.
//   Each command gives exactly one result beat on o_result, marked by
//   o_valid for a single cycle; the receiver cannot hold it off.
// Timing:
//   The accept edge reads both queue heads from their memories; the next
//   cycle decides, updates the queues and registers the result; o_valid
//   is registered alongside the result. busy stays high from the accept
//   until the result is registered, so a new command is not taken while
//   one is in flight, owing to the registered memory read of the head entries.
// Reset:
//   synchronous active-low i_rst_n empties both queues and clears the
//   arrival stamp; queue memories need no clearing.
`timescale 1ns / 1ps

module two_class_age_ordered_fifo_unit
    import tcaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    t_ctl ctl;

    // sequencer
    tcaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_ctl   (ctl)
    );

    // queues and result
    tcaf_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // an accepted beat always occupies the unit for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // a result beat only comes as busy falls after a command
    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a command in flight");

    // status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == ST_OK || o_result.status == ST_EMPTY
                     || o_result.status == ST_FULL))
        else $error("undefined status code");

    // a failed command reports no taken id and no dog class
    a_no_take_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK)
            |-> (o_result.taken_id == '0 && !o_result.taken_from_dog))
        else $error("id reported on a failed command");
`endif

endmodule
